// ===== hw/rtl/ckpb_pkg.sv =====
// Package for the chroma key pixel blend: shared types, codes and weight tables.
// Used by every module in hw/rtl; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package ckpb_pkg;

    localparam int unsigned NUM_CH = 3;
    localparam int unsigned WT_W   = 17;
    localparam int unsigned PROD_W = 27;

    localparam logic [WT_W-1:0] WT_ONE    = 17'h10000;
    localparam logic [7:0]      MASK_BG   = 8'd253;
    localparam logic [7:0]      MASK_FG   = 8'd0;
    localparam logic [8:0]      BG_LIFT   = 9'd5;
    localparam logic [8:0]      CH_MAX    = 9'd255;

    localparam longint QUAD_SCALE = 64'd10000000;
    localparam longint EDGE_SCALE = 64'd255;

    typedef logic [NUM_CH-1:0][7:0] t_pix;
    typedef logic [WT_W-1:0] t_weight;
    typedef logic [WT_W-1:0] t_weight_tab [256];

    typedef struct packed {
        logic valid;
        logic bg_sel;
    } t_stage_ctl;

    function automatic t_weight_tab quad_tab();
        t_weight_tab tab;
        longint      n;
        for (int i = 0; i < 256; i++) begin
            n = 64'd77 * i * i + 64'd5000000 - 64'd39215 * i;
            tab[i] = WT_W'((n * 64'd65536) / QUAD_SCALE);
        end
        return tab;
    endfunction

    function automatic t_weight_tab edge_tab();
        t_weight_tab tab;
        longint      w;
        for (int i = 0; i < 256; i++) begin
            w = (64'd163840 * i) / EDGE_SCALE;
            tab[i] = (w > 64'd65536) ? WT_ONE : WT_W'(w);
        end
        return tab;
    endfunction

    localparam t_weight_tab QUAD_WT = quad_tab();
    localparam t_weight_tab EDGE_WT = edge_tab();

endpackage
`default_nettype wire

// ===== hw/rtl/ckpb_pix_if.sv =====
// Input channel of the chroma key pixel blend: foreground, background, mask, distance.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ckpb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] fg_blue;
    logic [7:0] fg_green;
    logic [7:0] fg_red;
    logic [7:0] bg_blue;
    logic [7:0] bg_green;
    logic [7:0] bg_red;
    logic [7:0] mask_value;
    logic [7:0] key_distance;

    modport source (
        output valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
               mask_value, key_distance,
        input  ready
    );
    modport sink (
        input  valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
               mask_value, key_distance,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/ckpb_out_if.sv =====
// Output channel of the chroma key pixel blend: composited BGR pixel.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ckpb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;

    modport source (
        output valid, out_blue, out_green, out_red,
        input  ready
    );
    modport sink (
        input  valid, out_blue, out_green, out_red,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/chroma_key_pixel_blend.sv =====
// Chroma key pixel blend top level: weight select, three channel lanes, merge.
// Depends on ckpb_pkg, ckpb_pix_if, ckpb_out_if, ckpb_weight, ckpb_lane, ckpb_merge.
//
// Usage:
//   i_pix carries one pixel per beat: foreground and background BGR bytes, the
//   key mask byte and the key distance byte. o_pix carries the composited BGR
//   pixel, one beat out for every beat in, in order.
//   Each accepted input beat passes the weight, lane and output registers in order.
//   Throughput is one pixel per cycle while o_pix is not stalled: weight lookup, one
//   multiplier per color lane and the output register each take one pipeline stage.
//   Mask 253 outputs the background lifted by 5 and saturated at 255; mask 0
//   blends with a distance-dependent weight from a 256-entry table; other masks
//   blend with a mask-dependent weight from a second 256-entry table.
//   Reset (i_rst_n low, synchronous) empties the pipeline; i_pix.ready is high
//   once reset is released.
//   When the receiver stalls with o_pix.valid high, the whole pipeline holds and
//   i_pix.ready drops in the same cycle; up to three beats sit in flight.
`timescale 1ns / 1ps
`default_nettype none
module chroma_key_pixel_blend (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ckpb_pix_if.sink    i_pix,
    ckpb_out_if.source  o_pix
);
    logic                 en;
    ckpb_pkg::t_pix       in_fg, in_bg;
    ckpb_pkg::t_stage_ctl s1_ctl;
    ckpb_pkg::t_weight    s1_weight;
    ckpb_pkg::t_pix       s1_fg, s1_bg;
    ckpb_pkg::t_pix       s2_blend, s2_lift;
    ckpb_pkg::t_pix       out_pix;
    logic                 out_valid;

    assign in_fg = {i_pix.fg_red, i_pix.fg_green, i_pix.fg_blue};
    assign in_bg = {i_pix.bg_red, i_pix.bg_green, i_pix.bg_blue};
    assign i_pix.ready = en;

    ckpb_weight u_weight (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_pix.valid),
        .i_fg           (in_fg),
        .i_bg           (in_bg),
        .i_mask_value   (i_pix.mask_value),
        .i_key_distance (i_pix.key_distance),
        .o_ctl          (s1_ctl),
        .o_weight       (s1_weight),
        .o_fg           (s1_fg),
        .o_bg           (s1_bg)
    );

    for (genvar c = 0; c < ckpb_pkg::NUM_CH; c++) begin : g_lane
        ckpb_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_fg     (s1_fg[c]),
            .i_bg     (s1_bg[c]),
            .i_weight (s1_weight),
            .o_blend  (s2_blend[c]),
            .o_lift   (s2_lift[c])
        );
    end

    ckpb_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s1_ctl),
        .i_blend     (s2_blend),
        .i_lift      (s2_lift),
        .i_out_ready (o_pix.ready),
        .o_en        (en),
        .o_valid     (out_valid),
        .o_pix       (out_pix)
    );

    assign o_pix.valid     = out_valid;
    assign o_pix.out_blue  = out_pix[0];
    assign o_pix.out_green = out_pix[1];
    assign o_pix.out_red   = out_pix[2];
endmodule
`default_nettype wire

// ===== hw/rtl/ckpb_weight.sv =====
// First stage: selects the background weight from the mask and distance tables.
// Depends on ckpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ckpb_weight (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire ckpb_pkg::t_pix      i_fg,
    input  wire ckpb_pkg::t_pix      i_bg,
    input  wire logic [7:0]          i_mask_value,
    input  wire logic [7:0]          i_key_distance,
    output ckpb_pkg::t_stage_ctl     o_ctl,
    output ckpb_pkg::t_weight        o_weight,
    output ckpb_pkg::t_pix           o_fg,
    output ckpb_pkg::t_pix           o_bg
);
    ckpb_pkg::t_stage_ctl r_ctl, n_ctl;
    ckpb_pkg::t_weight    r_weight, n_weight;
    ckpb_pkg::t_pix       r_fg, r_bg;

    always_comb begin
        n_ctl.valid  = i_valid;
        n_ctl.bg_sel = (i_mask_value == ckpb_pkg::MASK_BG);
        if (i_mask_value == ckpb_pkg::MASK_FG) begin
            n_weight = ckpb_pkg::QUAD_WT[i_key_distance];
        end else begin
            n_weight = ckpb_pkg::EDGE_WT[i_mask_value];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_weight <= n_weight;
            r_fg     <= i_fg;
            r_bg     <= i_bg;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_weight = r_weight;
    assign o_fg     = r_fg;
    assign o_bg     = r_bg;
endmodule
`default_nettype wire

// ===== hw/rtl/ckpb_lane.sv =====
// One color channel lane: weighted blend fg + (bg - fg) * w, and background lift.
// Depends on ckpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ckpb_lane (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [7:0]        i_fg,
    input  wire logic [7:0]        i_bg,
    input  wire ckpb_pkg::t_weight i_weight,
    output logic [7:0]             o_blend,
    output logic [7:0]             o_lift
);
    logic signed [8:0]                   diff;
    logic signed [ckpb_pkg::PROD_W-1:0]  prod;
    logic signed [ckpb_pkg::PROD_W-1:0]  sum;
    logic [8:0]                          lift;
    logic [7:0]                          r_blend, r_lift;

    always_comb begin
        diff = $signed({1'b0, i_bg}) - $signed({1'b0, i_fg});
        prod = ckpb_pkg::PROD_W'(diff) * ckpb_pkg::PROD_W'($signed({1'b0, i_weight}));
        sum  = $signed(ckpb_pkg::PROD_W'({i_fg, 16'h0000})) + prod;
        lift = {1'b0, i_bg} + ckpb_pkg::BG_LIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blend <= sum[23:16];
            r_lift  <= (lift > ckpb_pkg::CH_MAX) ? 8'hFF : lift[7:0];
        end
    end

    assign o_blend = r_blend;
    assign o_lift  = r_lift;
endmodule
`default_nettype wire

// ===== hw/rtl/ckpb_merge.sv =====
// Merge stage: picks blended or lifted lanes into the output register; owns stall control.
// Depends on ckpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ckpb_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ckpb_pkg::t_stage_ctl i_ctl,
    input  wire ckpb_pkg::t_pix       i_blend,
    input  wire ckpb_pkg::t_pix       i_lift,
    input  wire logic                 i_out_ready,
    output logic                      o_en,
    output logic                      o_valid,
    output ckpb_pkg::t_pix            o_pix
);
    ckpb_pkg::t_stage_ctl r_ctl;
    logic                 r_valid;
    ckpb_pkg::t_pix       r_pix;

    assign o_en = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_ctl   <= i_ctl;
            r_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_pix <= r_ctl.bg_sel ? i_lift : i_blend;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
endmodule
`default_nettype wire

// ===== tb/sv/tb_chroma_key_pixel_blend.sv =====
// Testbench for chroma_key_pixel_blend: directed and random pixel beats checked against
// a local blend predictor, with random idling on both channels and receiver hold-off.
// Depends on ckpb_pkg, ckpb_pix_if, ckpb_out_if and the chroma_key_pixel_blend RTL.
`timescale 1ns / 1ps
module tb_chroma_key_pixel_blend;

    localparam int          PIPE_LATENCY  = 3;
    localparam int          WATCHDOG_MAX  = 2000;
    localparam int          HOLD_OFF_LEN  = 64;
    localparam longint      UNITY_WT      = 64'd65536;
    localparam logic [7:0]  EDGE_FULL     = 8'd102;

    typedef struct packed {
        logic [2:0][7:0] fg;
        logic [2:0][7:0] bg;
        logic [7:0]      mask;
        logic [7:0]      key_dist;
    } t_pixel_beat;

    typedef logic [2:0][7:0] t_bgr;

    logic i_clk;
    logic i_rst_n;

    ckpb_pix_if pix_bus ();
    ckpb_out_if out_bus ();

    chroma_key_pixel_blend DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_pix   (out_bus)
    );

    t_bgr        composite_q[$];
    int unsigned error_count  = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_bgr blend_pixel(input t_pixel_beat p);
        t_bgr            px;
        longint unsigned d;
        longint unsigned m;
        longint unsigned wt;
        longint unsigned acc;
        d = p.key_dist;
        m = p.mask;
        if (p.mask == ckpb_pkg::MASK_BG) begin
            for (int c = 0; c < 3; c++) begin
                acc = p.bg[c] + 64'd5;
                px[c] = (acc > 64'd255) ? 8'hFF : acc[7:0];
            end
        end else begin
            if (p.mask == ckpb_pkg::MASK_FG) begin
                wt = ((64'd77 * d * d + 64'd5000000 - 64'd39215 * d) * UNITY_WT)
                     / 64'd10000000;
            end else begin
                wt = (m * 64'd163840) / 64'd255;
                if (wt > UNITY_WT) wt = UNITY_WT;
            end
            for (int c = 0; c < 3; c++) begin
                acc = 64'(p.bg[c]) * wt + 64'(p.fg[c]) * (UNITY_WT - wt);
                px[c] = acc[23:16];
            end
        end
        return px;
    endfunction

    function automatic t_pixel_beat make_pixel(input logic [7:0] fb, fgr, fr,
                                               input logic [7:0] bb, bgr, br,
                                               input logic [7:0] m, d);
        t_pixel_beat p;
        p.fg       = {fr, fgr, fb};
        p.bg       = {br, bgr, bb};
        p.mask     = m;
        p.key_dist = d;
        return p;
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] v;
        case ($urandom_range(9))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_pixel_beat random_pixel();
        t_pixel_beat p;
        logic [7:0]  edge_marks [6];
        edge_marks = '{8'd1, 8'd101, EDGE_FULL, 8'd252, 8'd254, 8'd255};
        for (int c = 0; c < 3; c++) begin
            p.fg[c] = random_byte();
            p.bg[c] = random_byte();
        end
        p.key_dist = random_byte();
        case ($urandom_range(7))
            0, 1:    p.mask = ckpb_pkg::MASK_BG;
            2, 3:    p.mask = ckpb_pkg::MASK_FG;
            4:       p.mask = 8'($urandom_range(1, 101));
            5:       p.mask = edge_marks[$urandom_range(5)];
            default: p.mask = 8'($urandom);
        endcase
        return p;
    endfunction

    task automatic send_pixel(input t_pixel_beat p);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_bus.fg_blue      = p.fg[0];
        pix_bus.fg_green     = p.fg[1];
        pix_bus.fg_red       = p.fg[2];
        pix_bus.bg_blue      = p.bg[0];
        pix_bus.bg_green     = p.bg[1];
        pix_bus.bg_red       = p.bg[2];
        pix_bus.mask_value   = p.mask;
        pix_bus.key_distance = p.key_dist;
        pix_bus.valid        = 1'b1;
        do @(posedge i_clk); while (!pix_bus.ready);
        composite_q.push_back(blend_pixel(p));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        pix_bus.valid = 1'b0;
        while (composite_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic test_foreground_blend();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                              ckpb_pkg::MASK_FG, 8'd0));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                              ckpb_pkg::MASK_FG, 8'd0));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                              ckpb_pkg::MASK_FG, 8'd255));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                              ckpb_pkg::MASK_FG, 8'd255));
        send_pixel(make_pixel(8'd12, 8'd200, 8'd77, 8'd240, 8'd3, 8'd128,
                              ckpb_pkg::MASK_FG, 8'd128));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              ckpb_pkg::MASK_FG, 8'd170));
        wait_drained();
    endtask

    task automatic test_background_lift();
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              ckpb_pkg::MASK_BG, 8'd255));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'd251, 8'd250, 8'd0,
                              ckpb_pkg::MASK_BG, 8'd255));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'd255, 8'd0, 8'd249,
                              ckpb_pkg::MASK_BG, 8'd0));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                              ckpb_pkg::MASK_BG, 8'h55));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                              ckpb_pkg::MASK_BG, 8'h00));
        send_pixel(make_pixel(8'd9, 8'd99, 8'd199, 8'd252, 8'd253, 8'd254,
                              ckpb_pkg::MASK_BG, 8'd77));
        wait_drained();
    endtask

    task automatic test_edge_blend();
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'd1, 8'd255));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd101, 8'd0));
        send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd200, 8'd100, 8'd50, EDGE_FULL, 8'd9));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'd103, 8'd200));
        send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd252, 8'd128));
        send_pixel(make_pixel(8'd90, 8'd80, 8'd70, 8'd60, 8'd50, 8'd40, 8'd254, 8'd1));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd33, 8'd166, 8'd250, 8'd222, 8'd11, 8'd128, 8'd50, 8'd64));
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = HOLD_OFF_LEN;
        repeat (24) send_pixel(random_pixel());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_pixel(random_pixel());
        wait_drained();
    endtask

    initial begin
        int unsigned hold_left;
        hold_left     = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                out_bus.ready = 1'b0;
                hold_left--;
            end else begin
                out_bus.ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v, act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bgr want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (composite_q.size() == 0) begin
                $error("unexpected output beat: blue %0d green %0d red %0d",
                       out_bus.out_blue, out_bus.out_green, out_bus.out_red);
                error_count++;
            end else begin
                want = composite_q.pop_front();
                check_field("out_blue", want[0], out_bus.out_blue);
                check_field("out_green", want[1], out_bus.out_green);
                check_field("out_red", want[2], out_bus.out_red);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("[chroma_key_pixel_blend] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        pix_bus.valid        = 1'b0;
        pix_bus.fg_blue      = 8'h00;
        pix_bus.fg_green     = 8'h00;
        pix_bus.fg_red       = 8'h00;
        pix_bus.bg_blue      = 8'h00;
        pix_bus.bg_green     = 8'h00;
        pix_bus.bg_red       = 8'h00;
        pix_bus.mask_value   = 8'h00;
        pix_bus.key_distance = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_foreground_blend();
        test_background_lift();
        test_edge_blend();
        test_backpressure();
        test_random_traffic(330, 20, 80);
        test_random_traffic(330, 80, 20);
        test_random_traffic(340, 0, 0);

        if (error_count == 0) begin
            $display("[chroma_key_pixel_blend] OK");
        end else begin
            $display("[chroma_key_pixel_blend] ERROR");
        end
        $finish;
    end

endmodule
